// ===== src/mesl_pkg.sv =====
// shared types and constants for the memory error statistics logger
package mesl_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned WORD_STRIDE = 4;
  localparam int unsigned PAGE_SHIFT  = 12;

  localparam logic [31:0] OFFSET_MASK = 32'h0000_0fff;
  localparam logic [31:0] WORD_MASK   = (WORD_BITS >= 32) ? 32'hffff_ffff :
                                        ((32'd1 << WORD_BITS) - 32'd1);
  localparam logic [31:0] STRIDE_W    = 32'(WORD_STRIDE);

  localparam logic [31:0] LOW_PAGE_RST    = 32'h7fff_ffff;
  localparam logic [31:0] LOW_OFFSET_RST  = 32'h0000_0fff;
  localparam logic [5:0]  FEWEST_BITS_RST = 6'd32;

  localparam logic [1:0]  RUN_SINGLE = 2'd1;
  localparam logic [1:0]  RUN_PAIR   = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ADDR   = 2'd1,
    KIND_ECC    = 2'd2,
    KIND_PARITY = 2'd3
  } kind_t;

  function automatic logic [5:0] popcount32(input logic [31:0] x);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      n = n + {5'd0, x[i]};
    end
    return n;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

endpackage

// ===== src/mesl_in_if.sv =====
// error report channel
interface mesl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [31:0] expected;
  logic [31:0] observed;

  modport source (output valid, kind, address, expected, observed, input ready);
  modport sink   (input valid, kind, address, expected, observed, output ready);
endinterface

// ===== src/mesl_out_if.sv =====
// statistics result channel
interface mesl_out_if;
  logic        valid;
  logic        ready;
  logic        changed;
  logic [31:0] error_count;
  logic [31:0] low_page;
  logic [31:0] low_offset;
  logic [31:0] high_page;
  logic [31:0] high_offset;
  logic [31:0] bit_mask;
  logic [5:0]  fewest_bits;
  logic [5:0]  most_bits;
  logic [31:0] total_bits;
  logic [1:0]  longest_run;
  logic [31:0] corrected_count;

  modport source (output valid, changed, error_count, low_page, low_offset, high_page,
                  high_offset, bit_mask, fewest_bits, most_bits, total_bits, longest_run,
                  corrected_count, input ready);
  modport sink   (input valid, changed, error_count, low_page, low_offset, high_page,
                  high_offset, bit_mask, fewest_bits, most_bits, total_bits, longest_run,
                  corrected_count, output ready);
endinterface

// ===== src/memory_error_statistics_logger.sv =====
// top level: running statistics over memory test error reports
// a report passes the input register, then the statistics and result registers
// throughput: one report per cycle unless the result side stalls; one pass of compares,
// a popcount-fed adder and saturating counters feeds the statistics and result registers
// reset (rst_n low, synchronous) empties both stages and loads the statistics start values
module memory_error_statistics_logger
  import mesl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mesl_in_if.sink     in_ch,
  mesl_out_if.source  out_ch
);

  // stage 1: registered report, with difference word and its bit count precomputed
  logic        s1_valid_r;
  kind_t       s1_kind_r;
  logic [31:0] s1_addr_r;
  logic [31:0] s1_page_r;
  logic [31:0] s1_offset_r;
  logic [31:0] s1_diff_r;
  logic [5:0]  s1_nbits_r;
  // ecc report flagged as corrected, the read word itself is not kept
  logic        s1_corr_r;

  // statistics state
  logic [31:0] count_r;
  logic [31:0] low_page_r;
  logic [31:0] low_offset_r;
  logic [31:0] high_page_r;
  logic [31:0] high_offset_r;
  logic [31:0] mask_r;
  logic [5:0]  min_r;
  logic [5:0]  max_r;
  logic [31:0] total_r;
  logic [1:0]  run_r;
  logic [31:0] corrected_r;
  logic [31:0] last_addr_r;

  logic        out_valid_r;
  logic        changed_r;

  // next values
  logic [31:0] count_nxt;
  logic [31:0] low_page_nxt;
  logic [31:0] low_offset_nxt;
  logic [31:0] high_page_nxt;
  logic [31:0] high_offset_nxt;
  logic [31:0] mask_nxt;
  logic [5:0]  min_nxt;
  logic [5:0]  max_nxt;
  logic [31:0] total_nxt;
  logic [1:0]  run_nxt;
  logic [31:0] corrected_nxt;
  logic [31:0] last_addr_nxt;
  logic        changed_nxt;

  // front-end decode of the incoming report
  kind_t       in_kind;
  logic [31:0] in_diff;
  logic [31:0] in_page;
  logic [31:0] in_offset;

  // handshake
  logic out_free;
  logic s1_fire;
  logic in_fire;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign in_kind = kind_t'(in_ch.kind);

  // ecc reports carry page and offset directly and have no difference word
  always_comb begin
    if (in_kind == KIND_ECC) begin
      in_diff   = '0;
      in_page   = in_ch.address;
      in_offset = in_ch.expected;
    end else begin
      in_diff   = in_ch.expected ^ in_ch.observed;
      in_page   = in_ch.address >> PAGE_SHIFT;
      in_offset = in_ch.address & OFFSET_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // payload of stage 1 needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r   <= in_kind;
      s1_addr_r   <= in_ch.address;
      s1_page_r   <= in_page;
      s1_offset_r <= in_offset;
      s1_diff_r   <= in_diff;
      s1_nbits_r  <= popcount32(in_diff & WORD_MASK);
      s1_corr_r   <= (in_kind == KIND_ECC) && (in_ch.observed != '0);
    end
  end

  // stage 2: fold the report into the statistics
  always_comb begin
    logic [31:0] lp;
    logic [31:0] lo;
    logic [31:0] hp;
    logic [31:0] ho;
    logic        chg;
    logic        adjacent;

    lp  = low_page_r;
    lo  = low_offset_r;
    hp  = high_page_r;
    ho  = high_offset_r;
    chg = 1'b0;

    count_nxt     = sat_add32(count_r, 32'd1);
    mask_nxt      = mask_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    total_nxt     = total_r;
    run_nxt       = run_r;
    corrected_nxt = corrected_r;
    last_addr_nxt = last_addr_r;
    adjacent      = (s1_addr_r == last_addr_r + STRIDE_W) ||
                    (s1_addr_r == last_addr_r - STRIDE_W);

    // parity reports only bump the report count
    if (s1_kind_r != KIND_PARITY) begin
      if (s1_corr_r) begin
        corrected_nxt = sat_add32(corrected_r, 32'd1);
      end

      // low/high tracking; the low-page tie also rewrites the high offset
      priority if (low_page_r > s1_page_r) begin
        lp  = s1_page_r;
        lo  = s1_offset_r;
        chg = 1'b1;
      end else if (low_page_r == s1_page_r && low_offset_r > s1_offset_r) begin
        lo  = s1_offset_r;
        ho  = s1_offset_r;
        chg = 1'b1;
      end else if (high_page_r < s1_page_r) begin
        hp  = s1_page_r;
        chg = 1'b1;
      end else begin
        // page already inside the tracked range
      end
      if (hp == s1_page_r && ho < s1_offset_r) begin
        ho  = s1_offset_r;
        chg = 1'b1;
      end

      total_nxt = sat_add32(total_r, {26'd0, s1_nbits_r});
      if (s1_nbits_r > max_r) begin
        max_nxt = s1_nbits_r;
        chg     = 1'b1;
      end
      if (s1_nbits_r < min_r) begin
        min_nxt = s1_nbits_r;
        chg     = 1'b1;
      end
      // any difference from the stored mask counts, even with no new bit
      if ((mask_r ^ s1_diff_r) != '0) begin
        chg = 1'b1;
      end
      mask_nxt = mask_r | s1_diff_r;

      if (adjacent && run_r < RUN_PAIR) begin
        run_nxt = RUN_PAIR;
        chg     = 1'b1;
      end else if (!adjacent && run_r < RUN_SINGLE) begin
        run_nxt = RUN_SINGLE;
        chg     = 1'b1;
      end
      last_addr_nxt = s1_addr_r;
    end

    low_page_nxt    = lp;
    low_offset_nxt  = lo;
    high_page_nxt   = hp;
    high_offset_nxt = ho;
    changed_nxt     = chg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      low_page_r    <= LOW_PAGE_RST;
      low_offset_r  <= LOW_OFFSET_RST;
      high_page_r   <= '0;
      high_offset_r <= '0;
      mask_r        <= '0;
      min_r         <= FEWEST_BITS_RST;
      max_r         <= '0;
      total_r       <= '0;
      run_r         <= '0;
      corrected_r   <= '0;
      last_addr_r   <= '0;
    end else if (s1_fire) begin
      count_r       <= count_nxt;
      low_page_r    <= low_page_nxt;
      low_offset_r  <= low_offset_nxt;
      high_page_r   <= high_page_nxt;
      high_offset_r <= high_offset_nxt;
      mask_r        <= mask_nxt;
      min_r         <= min_nxt;
      max_r         <= max_nxt;
      total_r       <= total_nxt;
      run_r         <= run_nxt;
      corrected_r   <= corrected_nxt;
      last_addr_r   <= last_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      changed_r <= changed_nxt;
    end
  end

  // the statistics registers double as the result payload: they only move
  // when a new result is loaded into the output stage
  assign out_ch.valid           = out_valid_r;
  assign out_ch.changed         = changed_r;
  assign out_ch.error_count     = count_r;
  assign out_ch.low_page        = low_page_r;
  assign out_ch.low_offset      = low_offset_r;
  assign out_ch.high_page       = high_page_r;
  assign out_ch.high_offset     = high_offset_r;
  assign out_ch.bit_mask        = mask_r;
  assign out_ch.fewest_bits     = min_r;
  assign out_ch.most_bits       = max_r;
  assign out_ch.total_bits      = total_r;
  assign out_ch.longest_run     = run_r;
  assign out_ch.corrected_count = corrected_r;

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the memory error statistics logger
`timescale 1ns / 100ps

module testbench
  import mesl_pkg::*;
();

  // one error report as it crosses the input channel
  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [31:0] expected;
    logic [31:0] observed;
  } report_t;

  // one statistics snapshot as it leaves the block
  typedef struct packed {
    logic        changed;
    logic [31:0] error_count;
    logic [31:0] low_page;
    logic [31:0] low_offset;
    logic [31:0] high_page;
    logic [31:0] high_offset;
    logic [31:0] bit_mask;
    logic [5:0]  fewest_bits;
    logic [5:0]  most_bits;
    logic [31:0] total_bits;
    logic [1:0]  longest_run;
    logic [31:0] corrected_count;
  } stats_t;

  // running statistics of every accepted report, and the snapshots still owed
  class stats_scoreboard;
    stats_t      tally;
    logic [31:0] last_addr;
    stats_t      owed[$];
    int unsigned faults;

    function new();
      tally             = '0;
      tally.low_page    = LOW_PAGE_RST;
      tally.low_offset  = LOW_OFFSET_RST;
      tally.fewest_bits = FEWEST_BITS_RST;
      last_addr         = '0;
      faults            = 0;
    endfunction

    function string describe(stats_t s);
      return $sformatf({"chg %0b cnt %h low %h/%h high %h/%h mask %h bits %0d..%0d ",
                        "sum %h run %0d corr %h"},
                       s.changed, s.error_count, s.low_page, s.low_offset, s.high_page,
                       s.high_offset, s.bit_mask, s.fewest_bits, s.most_bits, s.total_bits,
                       s.longest_run, s.corrected_count);
    endfunction

    // fold one accepted report into the statistics and queue the snapshot
    function void note_report(report_t r);
      logic [31:0] diff;
      logic [31:0] page;
      logic [31:0] offset;
      logic [5:0]  nbits;
      logic [32:0] sum;
      logic [1:0]  run;
      tally.changed = 1'b0;
      if (tally.error_count != '1) tally.error_count++;
      if (r.kind != KIND_PARITY) begin
        if (r.kind == KIND_ECC) begin
          if (r.observed != '0 && tally.corrected_count != '1) tally.corrected_count++;
          diff   = '0;
          page   = r.address;
          offset = r.expected;
        end else begin
          diff   = r.expected ^ r.observed;
          page   = r.address >> PAGE_SHIFT;
          offset = r.address & OFFSET_MASK;
        end
        if (page < tally.low_page) begin
          tally.low_page   = page;
          tally.low_offset = offset;
          tally.changed    = 1'b1;
        end else if (page == tally.low_page && offset < tally.low_offset) begin
          // tie on the lowest page drags the high offset along with it
          tally.low_offset  = offset;
          tally.high_offset = offset;
          tally.changed     = 1'b1;
        end else if (page > tally.high_page) begin
          tally.high_page = page;
          tally.changed   = 1'b1;
        end
        if (page == tally.high_page && offset > tally.high_offset) begin
          tally.high_offset = offset;
          tally.changed     = 1'b1;
        end
        nbits = 6'($countones(diff & WORD_MASK));
        sum   = {1'b0, tally.total_bits} + 33'(nbits);
        tally.total_bits = sum[32] ? '1 : sum[31:0];
        if (nbits > tally.most_bits) begin
          tally.most_bits = nbits;
          tally.changed   = 1'b1;
        end
        if (nbits < tally.fewest_bits) begin
          tally.fewest_bits = nbits;
          tally.changed     = 1'b1;
        end
        // any difference from the stored mask counts, even with no new bit
        if (diff != tally.bit_mask) tally.changed = 1'b1;
        tally.bit_mask = tally.bit_mask | diff;
        run = (r.address == last_addr + STRIDE_W || r.address == last_addr - STRIDE_W) ?
              RUN_PAIR : RUN_SINGLE;
        if (run > tally.longest_run) begin
          tally.longest_run = run;
          tally.changed     = 1'b1;
        end
        last_addr = r.address;
      end
      owed.push_back(tally);
    endfunction

    function void check_stats(stats_t got);
      stats_t want;
      if (owed.size() == 0) begin
        faults++;
        if (faults <= 10) $display("result with none outstanding: %s", describe(got));
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        faults++;
        if (faults <= 10) begin
          $display("statistics mismatch");
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mesl_in_if  report_ch ();
  mesl_out_if stats_ch ();

  memory_error_statistics_logger uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (report_ch),
    .out_ch (stats_ch)
  );

  stats_scoreboard stats_board = new();

  // idling mix per phase, in percent
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned idle_mix[4]  = '{0, 73, 0, 17};
  int unsigned stall_mix[4] = '{0, 0, 73, 17};
  // long hold-off on the result side, raised by its own process
  logic        hold_receiver;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // safety net in case the block hangs
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // result side: check each transaction, then pick the next ready
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stats_ch.valid && stats_ch.ready) begin
        stats_board.check_stats(stats_t'{stats_ch.changed, stats_ch.error_count,
                                         stats_ch.low_page, stats_ch.low_offset,
                                         stats_ch.high_page, stats_ch.high_offset,
                                         stats_ch.bit_mask, stats_ch.fewest_bits,
                                         stats_ch.most_bits, stats_ch.total_bits,
                                         stats_ch.longest_run, stats_ch.corrected_count});
      end
      stats_ch.ready <= !hold_receiver && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one report, with a random gap first, and wait for its transaction
  task automatic send_report(input report_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      report_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    report_ch.valid    <= 1'b1;
    report_ch.kind     <= r.kind;
    report_ch.address  <= r.address;
    report_ch.expected <= r.expected;
    report_ch.observed <= r.observed;
    @(posedge clk);
    while (!report_ch.ready) @(posedge clk);
    stats_board.note_report(r);
  endtask

  // sender goes quiet until every owed snapshot has come back
  task automatic drain_results();
    report_ch.valid <= 1'b0;
    do @(posedge clk); while (stats_board.owed.size() != 0);
  endtask

  task automatic hold_results(input int unsigned cycles);
    hold_receiver <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_receiver <= 1'b0;
  endtask

  // random report, steered towards ties, adjacency and record values
  function automatic report_t random_report();
    report_t     r;
    int unsigned pick;
    logic [31:0] page;
    pick = $urandom_range(99);
    r.kind = (pick < 40) ? KIND_DATA : (pick < 60) ? KIND_ADDR :
             (pick < 85) ? KIND_ECC : KIND_PARITY;
    page = $urandom_range(1) ? stats_board.tally.low_page : stats_board.tally.high_page;
    r.expected = $urandom;
    r.observed = $urandom;
    if (r.kind == KIND_ECC) begin
      case ($urandom_range(3))
        0: r.address = stats_board.last_addr + ($urandom_range(1) ? STRIDE_W : -STRIDE_W);
        1: r.address = page;
        2: r.address = $urandom_range(0, 255);
        default: r.address = $urandom;
      endcase
      case ($urandom_range(2))
        0: r.expected = $urandom_range(0, 'hfff);
        1: r.expected = stats_board.tally.high_offset + 32'($urandom_range(0, 3));
        default: r.expected = $urandom;
      endcase
      if ($urandom_range(1)) r.observed = '0;
    end else if (r.kind != KIND_PARITY) begin
      case ($urandom_range(3))
        0: begin
          case ($urandom_range(3))
            0: r.address = stats_board.last_addr + STRIDE_W;
            1: r.address = stats_board.last_addr - STRIDE_W;
            2: r.address = stats_board.last_addr + 2 * STRIDE_W;
            default: r.address = stats_board.last_addr;
          endcase
        end
        1: r.address = {page[19:0], 12'($urandom)};
        2: r.address = {20'($urandom_range(0, 255)), 12'($urandom)};
        default: r.address = $urandom;
      endcase
      // bits in error: none, one, a few, random or the whole word
      case ($urandom_range(4))
        0: r.observed = r.expected;
        1: r.observed = r.expected ^ (32'd1 << $urandom_range(31));
        2: r.observed = r.expected ^ ($urandom & $urandom & $urandom);
        3: r.observed = $urandom;
        default: r.observed = ~r.expected;
      endcase
    end else begin
      r.address = $urandom;
    end
    return r;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n;
    rst_n              <= 1'b0;
    hold_receiver      <= 1'b0;
    report_ch.valid    <= 1'b0;
    report_ch.kind     <= KIND_DATA;
    report_ch.address  <= '0;
    report_ch.expected <= '0;
    report_ch.observed <= '0;
    stats_ch.ready     <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // parity straight after reset: only the count moves
    send_report(report_t'{KIND_PARITY, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000});
    // first data error, every bit wrong, strictly lower page
    send_report(report_t'{KIND_DATA, 32'h0001_2344, 32'h0000_0000, 32'hffff_ffff});
    // next word up, one bit, subset of the mask yet still a change; higher page
    send_report(report_t'{KIND_DATA, 32'h0001_2348, 32'h0000_0005, 32'h0000_0004});
    // same low page, smaller offset: high offset overwritten too; no bits wrong
    send_report(report_t'{KIND_ADDR, 32'h0001_2340, 32'h1234_5678, 32'h1234_5678});
    // word above last address, equal high page with a larger offset
    send_report(report_t'{KIND_DATA, 32'h0001_2344, 32'h8000_0001, 32'h0000_0000});
    // only the count and the bit total move, no change flagged: difference equals the mask
    send_report(report_t'{KIND_DATA, 32'h0001_2342, 32'hffff_ffff, 32'h0000_0000});
    // ecc on the top page with the largest offset, not corrected
    send_report(report_t'{KIND_ECC, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000});
    // corrected ecc, same page, small offset
    send_report(report_t'{KIND_ECC, 32'hffff_ffff, 32'h0000_0007, 32'h0000_0001});
    // ecc on page zero with an offset beyond the page size
    send_report(report_t'{KIND_ECC, 32'h0000_0000, 32'hffff_ffff, 32'h8000_0000});
    send_report(report_t'{KIND_DATA, 32'h0000_0fff, 32'haaaa_aaaa, 32'h5555_5555});
    send_report(report_t'{KIND_ADDR, 32'h0000_0000, 32'h0000_ffff, 32'hffff_0000});
    // adjacency across the wrap of the address space, both ways
    send_report(report_t'{KIND_DATA, 32'hffff_fffc, 32'h0f0f_0f0f, 32'h0f0f_0f0e});
    send_report(report_t'{KIND_DATA, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
    send_report(report_t'{KIND_PARITY, 32'h5a5a_5a5a, 32'h0000_0000, 32'hffff_ffff});
    send_report(report_t'{KIND_DATA, 32'h8000_0000, 32'h0000_ffff, 32'hffff_0000});
    send_report(report_t'{KIND_ECC, 32'h7fff_ffff, 32'h0000_0fff, 32'hffff_ffff});
    drain_results();

    // results held back while reports keep coming, so the input backs up
    fork
      hold_results(150);
      begin
        for (n = 0; n < 40; n++) send_report(random_report());
      end
    join
    drain_results();

    // random phases with different idling on each side
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_mix[phase];
      recv_stall_pct = stall_mix[phase];
      for (n = 0; n < 220; n++) send_report(random_report());
      drain_results();
    end

    // a little extra time to catch any stray results
    recv_stall_pct = 0;
    repeat (16) @(posedge clk);
    if (stats_board.faults == 0 && stats_board.owed.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
